// ===== src/ftpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftpt_pkg
// Shared constants, defaults and controller/datapath handshake types for the
// first-touch page translator.
// ----------------------------------------------------------------------------
package ftpt_pkg;

  localparam int ADDR_W      = 32;
  localparam int OWNER_W     = 4;
  localparam int PPN_W       = 20;

  // Default geometry
  localparam int SETS_DEF      = 256;
  localparam int WAYS_DEF      = 4;
  localparam int PAGE_BITS_DEF = 12;

  // First physical page handed out after reset
  localparam logic [PPN_W-1:0] FREE_PAGE_START = 20'h00100;

  typedef struct packed {
    logic load_in;   // latch the accepted item
    logic idx_step;  // advance the set index unit
    logic rd_en;     // read the set row
    logic clr_wr;    // write a cleared row during the clearing pass
    logic commit;    // resolve the lookup, write back, load the result
  } ftpt_cmd_t;

  typedef struct packed {
    logic idx_ready; // set index is final
    logic clr_last;  // clearing pass is on its last row
    logic out_stall; // result register still holds an untaken item
  } ftpt_sts_t;

endpackage : ftpt_pkg
`default_nettype wire

// ===== src/ftpt_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftpt_in_if
// Request channel: thread number and virtual address with valid/ready.
// ----------------------------------------------------------------------------
interface ftpt_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  thread_num;
  logic [31:0] virt_address;

  modport source (output valid, output thread_num, output virt_address, input ready);
  modport sink   (input valid, input thread_num, input virt_address, output ready);
endinterface : ftpt_in_if
`default_nettype wire

// ===== src/ftpt_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftpt_out_if
// Result channel: physical address and hit/overflow flags with valid/ready.
// ----------------------------------------------------------------------------
interface ftpt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] phys_address;
  logic        was_hit;
  logic        overflow;

  modport source (output valid, output phys_address, output was_hit, output overflow,
                  input ready);
  modport sink   (input valid, input phys_address, input was_hit, input overflow,
                  output ready);
endinterface : ftpt_out_if
`default_nettype wire

// ===== src/ftpt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftpt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ftpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                    wdata,
  input  wire logic                                re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : ftpt_ram
`default_nettype wire

// ===== src/ftpt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftpt_ctrl
// Sequencer: clearing pass, accept, set index, row read, resolve and commit.
// ----------------------------------------------------------------------------
module ftpt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output ftpt_pkg::ftpt_cmd_t      cmd,
  input  wire ftpt_pkg::ftpt_sts_t sts
);
  import ftpt_pkg::*;

  localparam logic [1:0] ST_CLEAR   = 2'd0;
  localparam logic [1:0] ST_IDLE    = 2'd1;
  localparam logic [1:0] ST_INDEX   = 2'd2;
  localparam logic [1:0] ST_RESOLVE = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_INDEX;
        end
      end
      ST_INDEX: begin
        cmd.idx_step = 1'b1;
        if (sts.idx_ready) begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        // hold the row until the result register is free
        if (!sts.out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule : ftpt_ctrl
`default_nettype wire

// ===== src/ftpt_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftpt_dp
// Datapath: item registers, set index unit, table RAM, way compare,
// allocation, free page counter and result register.
// ----------------------------------------------------------------------------
module ftpt_dp #(
  parameter int SETS      = ftpt_pkg::SETS_DEF,
  parameter int WAYS      = ftpt_pkg::WAYS_DEF,
  parameter int PAGE_BITS = ftpt_pkg::PAGE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic                         cfg_wr_data,
  input  wire logic [ftpt_pkg::OWNER_W-1:0] in_thread_num,
  input  wire logic [ftpt_pkg::ADDR_W-1:0]  in_virt_address,
  input  wire ftpt_pkg::ftpt_cmd_t          cmd,
  output ftpt_pkg::ftpt_sts_t               sts,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic [ftpt_pkg::ADDR_W-1:0]       out_phys_address,
  output logic                              out_was_hit,
  output logic                              out_overflow
);
  import ftpt_pkg::*;

  localparam int VPN_W    = ADDR_W - PAGE_BITS;
  localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENTRY_W  = 1 + OWNER_W + VPN_W + PPN_W;
  localparam int ROW_W    = WAYS * ENTRY_W;
  localparam int VPN_LSB  = PPN_W;
  localparam int OWN_LSB  = PPN_W + VPN_W;
  localparam int VLD_BIT  = ENTRY_W - 1;
  localparam bit SETS_POW2 = ((SETS & (SETS - 1)) == 0);

  function automatic logic [ADDR_W-1:0] join_addr(input logic [PPN_W-1:0] ppn,
                                                   input logic [PAGE_BITS-1:0] off);
    logic [ADDR_W-1:0] ext;
    ext = ADDR_W'(ppn);
    return (ext << PAGE_BITS) | ADDR_W'(off);
  endfunction

  // Item registers and configuration
  logic [OWNER_W-1:0]   thread_r;
  logic [VPN_W-1:0]     vpn_r;
  logic [PAGE_BITS-1:0] off_r;
  logic                 shared_r;
  logic [PPN_W-1:0]     next_free_r, next_free_nxt;
  logic [SET_W-1:0]     clr_cnt_r;
  logic [SET_W-1:0]     set_idx;
  logic                 idx_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      thread_r <= in_thread_num;
      vpn_r    <= in_virt_address[ADDR_W-1:PAGE_BITS];
      off_r    <= in_virt_address[PAGE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shared_r    <= 1'b0;
      next_free_r <= FREE_PAGE_START;
      clr_cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        shared_r <= cfg_wr_data;
      end
      next_free_r <= next_free_nxt;
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + SET_W'(1);
      end
    end
  end

  // Set index: mask for a power-of-two set count, else a reciprocal
  // multiply for the quotient, then a back-multiply and subtract
  if (SETS_POW2) begin : g_idx_mask
    logic [SET_W-1:0] set_idx_r;
    always_ff @(posedge clk) begin
      if (cmd.load_in) begin
        set_idx_r <= SET_W'(in_virt_address[ADDR_W-1:PAGE_BITS] & VPN_W'(SETS - 1));
      end
    end
    assign set_idx   = set_idx_r;
    assign idx_ready = 1'b1;
  end else begin : g_idx_rem
    localparam int          SHIFT  = VPN_W + SET_W;
    localparam int          RCP_W  = VPN_W + 1;
    localparam int          PROD_W = VPN_W + RCP_W;
    localparam logic [63:0] RCP    = ((64'd1 << SHIFT) + 64'(SETS - 1)) / 64'(SETS);

    logic [PROD_W-1:0] prod;
    logic [VPN_W-1:0]  quo_r;
    logic [VPN_W-1:0]  back;
    logic [SET_W-1:0]  rem_r;
    logic [1:0]        cnt_r;

    assign prod = PROD_W'(vpn_r) * PROD_W'(RCP[RCP_W-1:0]);
    assign back = quo_r * VPN_W'(SETS);

    always_ff @(posedge clk) begin
      if (cmd.idx_step && cnt_r == 2'd2) begin
        quo_r <= VPN_W'(prod >> SHIFT);
      end
      if (cmd.idx_step && cnt_r == 2'd1) begin
        rem_r <= SET_W'(vpn_r - back);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r <= '0;
      end else if (cmd.load_in) begin
        cnt_r <= 2'd2;
      end else if (cmd.idx_step && cnt_r != '0) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end

    assign set_idx   = rem_r;
    assign idx_ready = (cnt_r == '0);
  end

  // Table RAM: one row per set, WAYS entries per row
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata, wr_row;

  ftpt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (set_idx),
    .rdata (ram_rdata)
  );

  // Way compare and allocation
  logic [WAYS-1:0]    way_valid;
  logic [WAYS-1:0]    way_match;
  logic               hit;
  logic [PPN_W-1:0]   hit_ppn;
  logic               free_found;
  logic [WAY_W-1:0]   free_way;
  logic               alloc;
  logic [ENTRY_W-1:0] new_entry;

  always_comb begin
    hit        = 1'b0;
    hit_ppn    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      way_valid[w] = ram_rdata[w*ENTRY_W + VLD_BIT];
      way_match[w] = way_valid[w]
                   && (ram_rdata[w*ENTRY_W + VPN_LSB +: VPN_W] == vpn_r)
                   && (shared_r || ram_rdata[w*ENTRY_W + OWN_LSB +: OWNER_W] == thread_r);
    end
    // descend so the lowest way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (way_match[w]) begin
        hit     = 1'b1;
        hit_ppn = ram_rdata[w*ENTRY_W +: PPN_W];
      end
      if (!way_valid[w]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
    end
    alloc     = !hit && free_found;
    new_entry = {1'b1, thread_r, vpn_r, next_free_r};
    wr_row    = ram_rdata;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == free_way) begin
        wr_row[w*ENTRY_W +: ENTRY_W] = new_entry;
      end
    end
  end

  assign ram_we    = cmd.clr_wr || (cmd.commit && alloc);
  assign ram_waddr = cmd.clr_wr ? clr_cnt_r : set_idx;
  assign ram_wdata = cmd.clr_wr ? '0 : wr_row;

  assign next_free_nxt = (cmd.commit && alloc) ? next_free_r + PPN_W'(1) : next_free_r;

  // Result register
  logic out_valid_r;
  logic [ADDR_W-1:0] phys_r;
  logic hit_r, ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_r <= hit;
      ovf_r <= !hit && !free_found;
      if (hit) begin
        phys_r <= join_addr(hit_ppn, off_r);
      end else if (free_found) begin
        phys_r <= join_addr(next_free_r, off_r);
      end else begin
        phys_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_phys_address = phys_r;
  assign out_was_hit      = hit_r;
  assign out_overflow     = ovf_r;

  assign sts.idx_ready = idx_ready;
  assign sts.clr_last  = (clr_cnt_r == SET_W'(SETS - 1));
  assign sts.out_stall = out_valid_r && !out_ready;

endmodule : ftpt_dp
`default_nettype wire

// ===== src/first_touch_page_translator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_touch_page_translator
// Allocate-on-first-touch virtual to physical page translation through a
// hashed, set-associative page table.
// ----------------------------------------------------------------------------
// Each item carries a thread number and a virtual address; the page number
// picks a set (page number modulo SETS) and the WAYS ways of that set are
// compared against page and, unless shared_space is set, thread. A hit
// returns the stored physical page joined with the offset; a miss takes the
// next page from a 20-bit counter (starting at 0x100, wrapping) and writes it
// into the lowest free way; a miss into a full set allocates nothing and
// returns overflow with a zero address. After reset the table is swept clear,
// one set row per cycle, and no item is taken until the sweep ends;
// configuration writes are taken throughout. An item passes through accept,
// row read, and resolve and write-back when SETS is a power of two; otherwise
// the set index first takes a reciprocal multiply, then a back-multiply and
// subtract. Each item reads its table row once and writes it back at most once,
// and resolve waits while the result register is stalled. The result register
// lets the next item be accepted while a result still waits to be taken.
// ----------------------------------------------------------------------------
module first_touch_page_translator #(
  parameter int SETS      = ftpt_pkg::SETS_DEF,
  parameter int WAYS      = ftpt_pkg::WAYS_DEF,
  parameter int PAGE_BITS = ftpt_pkg::PAGE_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   cfg_wr_en,
  input  wire logic   cfg_wr_data,
  ftpt_in_if.sink     in_ch,
  ftpt_out_if.source  out_ch
);
  import ftpt_pkg::*;

  ftpt_cmd_t cmd;
  ftpt_sts_t sts;
  logic      in_ready;

  // Sequencer: owns input ready and steps the datapath
  ftpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  assign in_ch.ready = in_ready;

  // Datapath: table, compare, allocate, result register
  ftpt_dp #(
    .SETS      (SETS),
    .WAYS      (WAYS),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_thread_num    (in_ch.thread_num),
    .in_virt_address  (in_ch.virt_address),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_phys_address (out_ch.phys_address),
    .out_was_hit      (out_ch.was_hit),
    .out_overflow     (out_ch.overflow)
  );

`ifndef SYNTHESIS
  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !sts.out_stall)
    else $error("result register overwritten while stalled");

  // One item in flight: ready drops after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted while another is in flight");

  // Hit and overflow exclude each other
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.was_hit && out_ch.overflow))
    else $error("hit and overflow both set");

  // Overflow carries a zero address
  a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.overflow) |-> (out_ch.phys_address == '0))
    else $error("overflow with non-zero address");
`endif

endmodule : first_touch_page_translator
`default_nettype wire

// ===== test/first_touch_page_translator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_touch_page_translator_test
// Self-checking bench for the first-touch page translator: drives lookups
// under random valid/ready idling, predicts every translation with a shadow
// copy of the page table and compares each result item field by field.
// ----------------------------------------------------------------------------
module first_touch_page_translator_test;
  import ftpt_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int SETS         = SETS_DEF;
  localparam int WAYS         = WAYS_DEF;
  localparam int PAGE_BITS    = PAGE_BITS_DEF;
  localparam int VPN_W        = ADDR_W - PAGE_BITS;
  localparam int SET_W        = $clog2(SETS);
  localparam int ENTRIES      = SETS * WAYS;
  localparam int IDLE_PERCENT = 34;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 150;
  // Base of the few sets that random traffic crowds until they overflow
  localparam int CROWDED_SET  = 8'h40;
  localparam int CROWDED_SPAN = 8;

  typedef struct packed {
    logic [ADDR_W-1:0] phys_address;
    logic              was_hit;
    logic              overflow;
  } translation_t;

  typedef struct packed {
    logic [OWNER_W-1:0] thread;
    logic [VPN_W-1:0]   vpage;
  } touched_page_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  ftpt_in_if  in_ch ();
  ftpt_out_if out_ch ();

  first_touch_page_translator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow page table: the bench's own view of every way in every set
  logic               pt_valid [ENTRIES];
  logic [OWNER_W-1:0] pt_owner [ENTRIES];
  logic [VPN_W-1:0]   pt_vpage [ENTRIES];
  logic [PPN_W-1:0]   pt_ppage [ENTRIES];
  logic [PPN_W-1:0]   next_free_page;
  logic               shared_space_model;

  translation_t  expected_translations[$];
  touched_page_t allocated_pages[$];

  int error_count    = 0;
  int cycle_count    = 0;
  int sink_hold_left = 0;
  bit source_gaps    = 1'b1;
  bit sink_gaps      = 1'b1;

  // --------------------------------------------------------------------------
  // Translation predictor: walk the set, take the lowest matching valid way,
  // else allocate into the lowest free way, else flag overflow.
  // --------------------------------------------------------------------------
  function automatic translation_t predict_translation(input logic [OWNER_W-1:0] thread,
                                                        input logic [ADDR_W-1:0] addr);
    logic [VPN_W-1:0]     vpage;
    logic [PAGE_BITS-1:0] offset;
    logic [63:0]          joined;
    int                   base;
    int                   free_way;
    int                   hit_way;
    translation_t         result;
    vpage    = addr[ADDR_W-1:PAGE_BITS];
    offset   = addr[PAGE_BITS-1:0];
    base     = int'(vpage % SETS) * WAYS;
    free_way = -1;
    hit_way  = -1;
    result   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!pt_valid[base + w]) begin
        if (free_way < 0) free_way = w;
      end else if (hit_way < 0 && pt_vpage[base + w] == vpage &&
                   (shared_space_model || pt_owner[base + w] == thread)) begin
        hit_way = w;
      end
    end
    if (hit_way >= 0) begin
      joined = (64'(pt_ppage[base + hit_way]) << PAGE_BITS) + 64'(offset);
      result.phys_address = joined[ADDR_W-1:0];
      result.was_hit      = 1'b1;
    end else if (free_way < 0) begin
      // Full set: nothing allocated, counter untouched
      result.overflow = 1'b1;
    end else begin
      pt_valid[base + free_way] = 1'b1;
      pt_owner[base + free_way] = thread;
      pt_vpage[base + free_way] = vpage;
      pt_ppage[base + free_way] = next_free_page;
      joined = (64'(next_free_page) << PAGE_BITS) + 64'(offset);
      result.phys_address = joined[ADDR_W-1:0];
      // 20-bit counter, wraps to zero on its own
      next_free_page = next_free_page + 1'b1;
      allocated_pages.push_back('{thread: thread, vpage: vpage});
    end
    return result;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: idle at random, then offer the item until it is taken. Valid is
  // left high so that back-to-back items need no second assignment in a step.
  // --------------------------------------------------------------------------
  task automatic issue_lookup(input logic [OWNER_W-1:0] thread,
                              input logic [ADDR_W-1:0] addr);
    while (source_gaps && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.thread_num   <= thread;
    in_ch.virt_address <= addr;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_translations.push_back(predict_translation(thread, addr));
  endtask

  // Drop valid straight after the last accepted item and wait for every result
  task automatic finish_burst();
    in_ch.valid <= 1'b0;
    while (expected_translations.size() != 0) @(posedge clk);
  endtask

  // Only called with no item in flight; the write lands on the next edge
  task automatic write_shared_space(input logic value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shared_space_model = value;
  endtask

  // Mix of revisits to allocated pages, crowded sets and fully random pages
  task automatic issue_random_lookup();
    touched_page_t        pick;
    logic [OWNER_W-1:0]   thread;
    logic [VPN_W-1:0]     vpage;
    int                   choice;
    choice = $urandom_range(99);
    thread = OWNER_W'($urandom_range(15));
    vpage  = VPN_W'($urandom);
    if (choice < 45 && allocated_pages.size() != 0) begin
      pick  = allocated_pages[$urandom_range(allocated_pages.size() - 1)];
      vpage = pick.vpage;
      if ($urandom_range(99) < 70) thread = pick.thread;
    end else if (choice < 75) begin
      vpage[SET_W-1:0] = SET_W'(CROWDED_SET + $urandom_range(CROWDED_SPAN - 1));
    end
    issue_lookup(thread, {vpage, PAGE_BITS'($urandom)});
  endtask

  // --------------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------------

  // Extremes of thread, page and offset; private spaces keep threads apart
  task automatic test_field_extremes();
    write_shared_space(1'b0);
    issue_lookup(4'h0, 32'h0000_0000);   // first allocation takes the start page
    issue_lookup(4'h0, 32'hFFFF_FFFF);   // top page, top offset
    issue_lookup(4'hF, 32'h0000_0FFF);   // same page, other thread: new way
    issue_lookup(4'h0, 32'h0000_0ABC);   // hit for thread 0
    issue_lookup(4'hF, 32'h0000_0000);   // hit for thread 15
    issue_lookup(4'hF, 32'hFFFF_F000);   // top page again, other owner
    issue_lookup(4'h0, 32'hFFFF_F555);   // hit on the top page
    finish_burst();
  endtask

  // Fill one set, then miss into it: overflow with a zero address
  task automatic test_full_set_overflow();
    issue_lookup(4'h3, 32'h0000_5123);
    issue_lookup(4'h3, 32'h0010_5456);
    issue_lookup(4'h3, 32'h0020_5789);
    issue_lookup(4'h3, 32'h0030_5ABC);
    issue_lookup(4'h3, 32'h0040_5DEF);   // fifth page in a four-way set
    issue_lookup(4'h3, 32'h0020_5001);   // existing pages still hit
    issue_lookup(4'h4, 32'h0000_5002);   // foreign owner, set full
    finish_burst();
  endtask

  // Two owners take one page privately; once shared, the lower way answers
  task automatic test_lowest_way_wins();
    issue_lookup(4'h1, 32'h1234_5010);
    issue_lookup(4'h2, 32'h1234_5020);
    finish_burst();
    write_shared_space(1'b1);
    issue_lookup(4'h9, 32'h1234_5030);
    issue_lookup(4'h2, 32'h1234_5040);
    issue_lookup(4'h7, 32'h2234_5050);   // new page under shared space
    issue_lookup(4'h8, 32'h2234_5060);   // any thread hits it
    finish_burst();
    write_shared_space(1'b0);
  endtask

  task automatic test_random_traffic(input int count, input logic shared, input bit gaps);
    write_shared_space(shared);
    source_gaps = gaps;
    sink_gaps   = gaps;
    repeat (count) issue_random_lookup();
    finish_burst();
    source_gaps = 1'b1;
    sink_gaps   = 1'b1;
  endtask

  // Hold the receiver off while items keep coming, so the input stalls
  task automatic test_result_backpressure();
    sink_hold_left <= HOLD_CYCLES;
    source_gaps = 1'b0;
    repeat (40) issue_random_lookup();
    finish_burst();
    source_gaps = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Result receiver: counts down a requested hold-off, else idles at random
  // --------------------------------------------------------------------------
  initial begin : result_receiver
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_left != 0) begin
        out_ch.ready   <= 1'b0;
        sink_hold_left <= sink_hold_left - 1;
      end else if (sink_gaps && $urandom_range(99) < IDLE_PERCENT) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each taken item with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_checker
    translation_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_translations.size() == 0) begin
        $display("%0t ERROR result with none expected: phys_address %h hit %b overflow %b",
                 $time, out_ch.phys_address, out_ch.was_hit, out_ch.overflow);
        error_count++;
      end else begin
        want = expected_translations.pop_front();
        if (out_ch.phys_address !== want.phys_address) begin
          $display("%0t ERROR phys_address expected %h actual %h",
                   $time, want.phys_address, out_ch.phys_address);
          error_count++;
        end
        if (out_ch.was_hit !== want.was_hit) begin
          $display("%0t ERROR was_hit expected %b actual %b",
                   $time, want.was_hit, out_ch.was_hit);
          error_count++;
        end
        if (out_ch.overflow !== want.overflow) begin
          $display("%0t ERROR overflow expected %b actual %b",
                   $time, want.overflow, out_ch.overflow);
          error_count++;
        end
      end
    end
  end

  // Guard against a hung handshake, clearing pass included
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : test_sequence
    in_ch.valid        = 1'b0;
    in_ch.thread_num   = '0;
    in_ch.virt_address = '0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = 1'b0;
    rst_n              = 1'b0;
    for (int i = 0; i < ENTRIES; i++) pt_valid[i] = 1'b0;
    next_free_page     = FREE_PAGE_START;
    shared_space_model = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_full_set_overflow();
    test_lowest_way_wins();
    test_random_traffic(350, 1'b0, 1'b1);
    test_result_backpressure();
    // Long stretch without idling on either side, shared space
    test_random_traffic(200, 1'b1, 1'b0);
    test_random_traffic(120, 1'b1, 1'b1);
    test_random_traffic(300, 1'b0, 1'b1);

    // Let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule : first_touch_page_translator_test
